@@ rtl/bli_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the bounded list insert/delete block
// no dependencies
package bli_pkg;

  // opcodes carried in the input beat
  localparam logic [1:0] OP_INS_FRONT = 2'd0;
  localparam logic [1:0] OP_INS_BACK  = 2'd1;
  localparam logic [1:0] OP_DELETE    = 2'd2;
  localparam logic [1:0] OP_REPORT    = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] operand;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic               is_last;
    logic               list_empty;
    logic               insert_dropped;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_LIST_RD,
    ST_LIST_OUT
  } state_t;

endpackage

@@ rtl/bounded_list_insert_delete_top.sv @@
`timescale 1ns / 1ps
// Bounded list insert/delete block: ring store in one synchronous memory
// Depends on bli_pkg
//
// Keeps up to CAPACITY signed 32-bit values as a ring in one memory with one
// write and one registered read port. An item is taken only while the block is
// idle. An insert writes its entry in the accept cycle; a delete at index k
// moves the entries above k down one entry a cycle. ST_LIST_RD then starts the
// first memory read, and the list goes out one element a cycle while out_stall
// is low (a single beat for an empty list). The single memory port sets the pace
// of both the shift and the listing. No clearing pass is needed after reset.
module bounded_list_insert_delete_top
  import bli_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // ring position of a logical index, front + index folded once
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] f,
                                            input logic [CW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, f} + (AW+1)'(l);
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  state_t        state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          wpend_r, wpend_nxt;
  logic [CW-1:0] li_r, li_nxt;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  logic [AW-1:0] front_dec;
  logic          full;
  logic          del_ok;
  logic [CW-1:0] del_idx;
  logic          list_last;

  assign front_dec = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - 1'b1;
  assign full      = (count_r == CW'(CAPACITY));
  assign del_idx   = in_data.operand[CW-1:0];
  assign del_ok    = !in_data.operand[31] && (in_data.operand[30:0] < 31'(count_r));
  assign list_last = (count_r == '0) || ((li_r + 1'b1) == count_r);

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      count_r <= '0;
      drop_r  <= 1'b0;
      wpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      wpend_r <= wpend_nxt;
    end
  end

  // index counters
  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
    wr_r <= wr_nxt;
    li_r <= li_nxt;
  end

  // next state, memory access and beat outputs
  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    wpend_nxt = wpend_r;
    li_nxt    = li_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = front_r;
    raddr     = front_r;
    wdata     = in_data.operand;
    in_stall  = (state_r != ST_IDLE);
    out_valid = 1'b0;
    out_data.item_value     = (count_r == '0) ? '0 : rdata_r;
    out_data.is_last        = list_last;
    out_data.list_empty     = (count_r == '0);
    out_data.insert_dropped = drop_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          drop_nxt  = 1'b0;
          state_nxt = ST_LIST_RD;
          case (in_data.opcode)
            OP_INS_FRONT: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                waddr     = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_INS_BACK: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                waddr     = ring_pos(front_r, count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            OP_DELETE: begin
              if (del_ok) begin
                if ((del_idx + 1'b1) < count_r) begin
                  rd_nxt    = del_idx + 1'b1;
                  wr_nxt    = del_idx;
                  wpend_nxt = 1'b0;
                  state_nxt = ST_SHIFT;
                end else begin
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            default: begin
              state_nxt = ST_LIST_RD;
            end
          endcase
        end
      end

      // move the tail down one entry a cycle, read ahead of write
      ST_SHIFT: begin
        if (rd_r < count_r) begin
          mem_re    = 1'b1;
          raddr     = ring_pos(front_r, rd_r);
          rd_nxt    = rd_r + 1'b1;
          wpend_nxt = 1'b1;
        end else begin
          wpend_nxt = 1'b0;
          count_nxt = count_r - 1'b1;
          state_nxt = ST_LIST_RD;
        end
        if (wpend_r) begin
          mem_we = 1'b1;
          waddr  = ring_pos(front_r, wr_r);
          wdata  = rdata_r;
          wr_nxt = wr_r + 1'b1;
        end
      end

      // fetch the front element
      ST_LIST_RD: begin
        mem_re    = 1'b1;
        raddr     = front_r;
        li_nxt    = '0;
        state_nxt = ST_LIST_OUT;
      end

      // one beat per element, next read starts when this beat is taken
      ST_LIST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (list_last) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_re = 1'b1;
            raddr  = ring_pos(front_r, li_r + 1'b1);
            li_nxt = li_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // element count stays within the store
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  // insert into a full store is flagged on the listing
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && full &&
     (in_data.opcode == OP_INS_FRONT || in_data.opcode == OP_INS_BACK))
    |=> drop_r && (count_r == CW'(CAPACITY)))
    else $error("full insert not dropped");

  // empty listing is a single final beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.list_empty) |-> out_data.is_last)
    else $error("empty beat not marked last");

  // taking the last beat returns the block to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.is_last) |=> (!out_valid && !in_stall))
    else $error("block not idle after last beat");
`endif

endmodule
